@@ design/psp_pkg.sv @@
// Package for the parallax starfield plotter: shared constants, types and helpers.
// No dependencies; every other design file refers to it by scoped names.
package psp_pkg;

  // Widths of the fixed fields.
  localparam int COORD_W = 11;
  localparam int DEPTH_W = 5;
  localparam int COLOR_W = 24;
  localparam int INDEX_W = 20;
  localparam int CENTER_W = 30;
  localparam int LEVEL_W = 8;
  localparam int DATA_W = 30;
  localparam int REG_IDX_W = 3;

  // Positions inside the field never reach 4096.
  localparam int POS_W = 12;

  // Divider widths: 32-bit dividend, divisor up to 4096, reciprocal up to 2**32.
  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W = 13;
  localparam int RECIP_W = 33;

  // Default sizes.
  localparam int FIELD_WIDTH_DEF = 1024;
  localparam int FIELD_HEIGHT_DEF = 1024;
  localparam int MAX_DEPTH_DEF = 20;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_VIEW_LEFT  = 3'd2,
    REG_VIEW_TOP   = 3'd3,
    REG_VIEW_RIGHT = 3'd4,
    REG_VIEW_BOTTOM = 3'd5,
    REG_BG_LEVEL   = 3'd6
  } reg_index_t;

  // Pending-write mask bits, in output order.
  localparam int WR_RIGHT = 0;
  localparam int WR_DOWN = 1;
  localparam int WR_LEFT = 2;
  localparam int WR_UP = 3;
  localparam int WR_CENTER = 4;
  localparam int WR_N = 5;

  // One star after placement, as handed to the write sequencer.
  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [COLOR_W-1:0] color;
    logic [COLOR_W-1:0] spike;
    logic [WR_N-1:0]    mask;
  } psp_star_t;

  // Largest of the three 8-bit channels of a packed color.
  function automatic logic [7:0] max_channel(input logic [COLOR_W-1:0] c);
    logic [7:0] m;
    begin
      m = (c[23:16] > c[15:8]) ? c[23:16] : c[15:8];
      max_channel = (m > c[7:0]) ? m : c[7:0];
    end
  endfunction

endpackage

@@ design/psp_star_if.sv @@
// Channel interfaces for the plotter: star words in, pixel-write words out.
// Depends on psp_pkg for field widths.
interface psp_star_if;
  logic valid;
  logic ready;
  logic [psp_pkg::COORD_W-1:0] star_x;
  logic [psp_pkg::COORD_W-1:0] star_y;
  logic [psp_pkg::DEPTH_W-1:0] star_depth;
  logic [psp_pkg::COLOR_W-1:0] star_color;
  logic [psp_pkg::COLOR_W-1:0] spike_color;
  logic bright_star;

  modport source (output valid, star_x, star_y, star_depth, star_color, spike_color,
                  bright_star, input ready);
  modport sink (input valid, star_x, star_y, star_depth, star_color, spike_color,
                bright_star, output ready);
  modport monitor (input valid, ready, star_x, star_y, star_depth, star_color, spike_color,
                   bright_star);
endinterface

interface psp_pixel_if;
  logic valid;
  logic ready;
  logic [psp_pkg::INDEX_W-1:0] pixel_index;
  logic [psp_pkg::COLOR_W-1:0] pixel_color;
  logic last_write;

  modport source (output valid, pixel_index, pixel_color, last_write, input ready);
  modport sink (input valid, pixel_index, pixel_color, last_write, output ready);
  modport monitor (input valid, ready, pixel_index, pixel_color, last_write);
endinterface

@@ design/psp_div.sv @@
// Pipelined unsigned divider by reciprocal multiplication, three register stages.
// Depends on psp_pkg for widths; the caller supplies floor(2**32 / divisor).
module psp_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic [psp_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [psp_pkg::DIVISOR_W-1:0]    divisor,
  input  logic [psp_pkg::RECIP_W-1:0]      recip,
  output logic [psp_pkg::DIVIDEND_W-1:0]   quo,
  output logic [psp_pkg::DIVISOR_W-1:0]    rem
);

  localparam int AW = psp_pkg::DIVIDEND_W;
  localparam int DW = psp_pkg::DIVISOR_W;
  localparam int PW = AW + psp_pkg::RECIP_W;

  logic [PW-1:0] prod;
  logic [AW-1:0] a1, a2;
  logic [DW-1:0] d1, d2;
  logic [AW-1:0] q0, q2;
  logic [AW+DW-1:0] back;
  logic [AW-1:0] bsub;
  logic [DW:0] r;

  // Stage 1: estimate quotient, short by at most one.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'(dividend) * PW'(recip);
      a1 <= dividend;
      d1 <= divisor;
    end
  end

  assign q0 = prod[PW-2 -: AW];

  // Stage 2: multiply the estimate back.
  always_ff @(posedge clk) begin
    if (en) begin
      back <= (AW+DW)'(q0) * (AW+DW)'(d1);
      q2 <= q0;
      a2 <= a1;
      d2 <= d1;
    end
  end

  // Stage 3: remainder below twice the divisor; one correction step.
  assign bsub = a2 - back[AW-1:0];
  assign r = bsub[DW:0];

  always_ff @(posedge clk) begin
    if (en) begin
      if (r >= (DW+1)'(d2)) begin
        quo <= q2 + AW'(1);
        rem <= DW'(r - (DW+1)'(d2));
      end else begin
        quo <= q2;
        rem <= DW'(r);
      end
    end
  end

endmodule

@@ design/psp_axis.sv @@
// One axis of star placement: parallax offset, shift and wrap into the field.
// Depends on psp_pkg and psp_div; every register advances only when en is high.
module psp_axis #(
  parameter int FIELD = psp_pkg::FIELD_WIDTH_DEF,
  parameter int MAX_DEPTH = psp_pkg::MAX_DEPTH_DEF,
  parameter bit SUB = 1'b1
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [psp_pkg::COORD_W-1:0]    coord,
  input  logic [psp_pkg::DEPTH_W-1:0]    depth,
  input  logic [psp_pkg::CENTER_W-1:0]   center,
  output logic [psp_pkg::POS_W-1:0]      pos
);

  localparam int DI_W = $clog2(MAX_DEPTH + 1);
  localparam int AW = psp_pkg::DIVIDEND_W;
  localparam int DW = psp_pkg::DIVISOR_W;
  localparam int RW = psp_pkg::RECIP_W;
  localparam int CW = psp_pkg::COORD_W;
  localparam int TW = AW + 2;
  localparam logic [63:0] FIELD_RECIP = (64'd1 << 32) / 64'(FIELD);

  logic [RW-1:0] rcp_tab [MAX_DEPTH+1];
  logic [DW-1:0] sq_tab [MAX_DEPTH+1];

  // Reciprocal and square of each depth, worked out at elaboration.
  for (genvar g = 0; g <= MAX_DEPTH; g++) begin : g_tab
    if (g == 0) begin : g_zero
      assign rcp_tab[g] = RW'(1);
      assign sq_tab[g] = DW'(1);
    end else begin : g_nz
      localparam logic [63:0] RV = (64'd1 << 32) / 64'(g * g);
      assign rcp_tab[g] = RW'(RV);
      assign sq_tab[g] = DW'(g * g);
    end
  end

  logic [DI_W-1:0] didx;
  logic [AW-1:0] c4, cmag;

  // Clamp depth; take magnitude of four times the center.
  assign didx = (32'(depth) > MAX_DEPTH) ? DI_W'(MAX_DEPTH) : DI_W'(depth);
  assign c4 = {center, 2'b00};
  assign cmag = c4[AW-1] ? (AW'(0) - c4) : c4;

  logic [AW-1:0] a0;
  logic [DW-1:0] d0;
  logic [RW-1:0] r0;
  logic neg0, zero0;
  logic [CW-1:0] coord0;

  // Stage A0: operand register.
  always_ff @(posedge clk) begin
    if (en) begin
      a0 <= cmag;
      d0 <= sq_tab[didx];
      r0 <= rcp_tab[didx];
      neg0 <= center[psp_pkg::CENTER_W-1];
      zero0 <= (didx == '0);
      coord0 <= coord;
    end
  end

  logic [AW-1:0] q1;
  logic [DW-1:0] rem1;

  psp_div u_pdiv (
    .clk(clk), .en(en), .dividend(a0), .divisor(d0), .recip(r0), .quo(q1), .rem(rem1)
  );

  logic [2:0] neg_d, zero_d;
  logic [CW-1:0] coord_d [3];

  // Sideband alongside the offset divider.
  always_ff @(posedge clk) begin
    if (en) begin
      neg_d <= {neg_d[1:0], neg0};
      zero_d <= {zero_d[1:0], zero0};
      coord_d[0] <= coord0;
      coord_d[1] <= coord_d[0];
      coord_d[2] <= coord_d[1];
    end
  end

  logic [AW-1:0] off;
  logic sub_eff;
  logic [TW-1:0] t;
  logic [AW-1:0] tmag;
  logic [AW-1:0] a4;
  logic tneg4;

  // Shifted coordinate; sign of the offset follows the center.
  assign off = zero_d[2] ? AW'(1) : q1;
  assign sub_eff = SUB ^ (neg_d[2] & ~zero_d[2]);
  assign t = sub_eff ? (TW'(coord_d[2]) - TW'(off)) : (TW'(coord_d[2]) + TW'(off));
  assign tmag = t[TW-1] ? AW'(TW'(0) - t) : AW'(t);

  // Stage A4: magnitude of shifted coordinate.
  always_ff @(posedge clk) begin
    if (en) begin
      a4 <= tmag;
      tneg4 <= t[TW-1];
    end
  end

  logic [AW-1:0] q5;
  logic [DW-1:0] rem5;

  psp_div u_wdiv (
    .clk(clk), .en(en), .dividend(a4), .divisor(DW'(FIELD)), .recip(RW'(FIELD_RECIP)),
    .quo(q5), .rem(rem5)
  );

  logic [2:0] tneg_d;

  always_ff @(posedge clk) begin
    if (en) begin
      tneg_d <= {tneg_d[1:0], tneg4};
    end
  end

  // Wrap negative values up into the field.
  always_ff @(posedge clk) begin
    if (en) begin
      if (tneg_d[2] && rem5 != '0) begin
        pos <= psp_pkg::POS_W'(DW'(FIELD) - rem5);
      end else begin
        pos <= psp_pkg::POS_W'(rem5);
      end
    end
  end

  // Quotient of the wrap and remainder of the offset are not needed.
  logic unused_q;
  assign unused_q = ^{q5, rem1};

endmodule

@@ design/psp_emit.sv @@
// Write sequencer: holds one placed star and issues its pixel writes in order.
// Depends on psp_pkg and psp_pixel_if.
module psp_emit #(
  parameter int FIELD = psp_pkg::FIELD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load_valid,
  input  psp_pkg::psp_star_t   load,
  output logic                 can_load,
  psp_pixel_if.source          pixel_out
);

  localparam int IW = psp_pkg::INDEX_W;
  localparam int N = psp_pkg::WR_N;

  logic ex_valid;
  logic [N-1:0] pend;
  logic [IW-1:0] idx;
  logic [psp_pkg::COLOR_W-1:0] color, spike;
  logic [N-1:0] low_bit;
  logic accept;

  assign low_bit = pend & (N'(0) - pend);
  assign accept = pixel_out.valid && pixel_out.ready;
  assign can_load = !ex_valid || (accept && (pend == low_bit));

  // Sequencer register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (can_load) begin
      ex_valid <= load_valid && (load.mask != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      pend <= load.mask;
      idx <= load.idx;
      color <= load.color;
      spike <= load.spike;
    end else if (accept) begin
      pend <= pend & ~low_bit;
    end
  end

  // Current word: lowest pending write.
  always_comb begin
    pixel_out.valid = ex_valid;
    pixel_out.pixel_color = spike;
    pixel_out.last_write = 1'b0;
    if (pend[psp_pkg::WR_RIGHT]) begin
      pixel_out.pixel_index = idx + IW'(1);
    end else if (pend[psp_pkg::WR_DOWN]) begin
      pixel_out.pixel_index = idx + IW'(FIELD);
    end else if (pend[psp_pkg::WR_LEFT]) begin
      pixel_out.pixel_index = idx - IW'(1);
    end else if (pend[psp_pkg::WR_UP]) begin
      pixel_out.pixel_index = idx - IW'(FIELD);
    end else begin
      pixel_out.pixel_index = idx;
      pixel_out.pixel_color = color;
      pixel_out.last_write = 1'b1;
    end
  end

endmodule

@@ design/parallax_starfield_plotter.sv @@
// Parallax starfield plotter: one star per cycle in, one pixel write per cycle out,
// while the receiver is ready. A star passes through each axis (two reciprocal
// dividers, one for the parallax offset and one for the wrap into the field), the
// view test and address register and the write sequencer. A star that lands in the
// view and outshines the background gives one write, or five when bright with a
// visible spike (three on the first or last row); a star with more writes holds the
// input side until its last write is taken, all others pass at one per cycle.
// Configuration is written through write_enable, reg_index and write_data; the user
// must write it only while no star is in flight; the block does not enforce this.
module parallax_starfield_plotter #(
  parameter int FIELD_WIDTH = psp_pkg::FIELD_WIDTH_DEF,
  parameter int FIELD_HEIGHT = psp_pkg::FIELD_HEIGHT_DEF,
  parameter int MAX_DEPTH = psp_pkg::MAX_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  psp_star_if.sink                          star_in,
  psp_pixel_if.source                       pixel_out,
  input  logic                              write_enable,
  input  logic [psp_pkg::REG_IDX_W-1:0]     reg_index,
  input  logic [psp_pkg::DATA_W-1:0]        write_data
);

  localparam int LAT = 9;
  localparam int CW = psp_pkg::COORD_W;
  localparam int PW = psp_pkg::POS_W;
  localparam int IW = psp_pkg::INDEX_W;
  localparam int COLW = psp_pkg::COLOR_W;

  logic [psp_pkg::CENTER_W-1:0] center_x, center_y;
  logic [CW-1:0] view_left, view_top, view_right, view_bottom;
  logic [psp_pkg::LEVEL_W-1:0] background_level;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      view_left <= '0;
      view_top <= '0;
      view_right <= CW'(1024);
      view_bottom <= CW'(1024);
      background_level <= '0;
    end else if (write_enable) begin
      case (psp_pkg::reg_index_t'(reg_index))
        psp_pkg::REG_CENTER_X: center_x <= write_data;
        psp_pkg::REG_CENTER_Y: center_y <= write_data;
        psp_pkg::REG_VIEW_LEFT: view_left <= write_data[CW-1:0];
        psp_pkg::REG_VIEW_TOP: view_top <= write_data[CW-1:0];
        psp_pkg::REG_VIEW_RIGHT: view_right <= write_data[CW-1:0];
        psp_pkg::REG_VIEW_BOTTOM: view_bottom <= write_data[CW-1:0];
        psp_pkg::REG_BG_LEVEL: background_level <= write_data[psp_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  logic en, can_load;
  logic [LAT:0] vld;

  // The whole pipeline moves when its last stage can hand off.
  assign en = !vld[LAT] || can_load;
  assign star_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:0], star_in.valid};
    end
  end

  logic [PW-1:0] pos_x, pos_y;

  psp_axis #(.FIELD(FIELD_WIDTH), .MAX_DEPTH(MAX_DEPTH), .SUB(1'b1)) u_ax_x (
    .clk(clk), .en(en), .coord(star_in.star_x), .depth(star_in.star_depth),
    .center(center_x), .pos(pos_x)
  );

  psp_axis #(.FIELD(FIELD_HEIGHT), .MAX_DEPTH(MAX_DEPTH), .SUB(1'b0)) u_ax_y (
    .clk(clk), .en(en), .coord(star_in.star_y), .depth(star_in.star_depth),
    .center(center_y), .pos(pos_y)
  );

  logic [COLW-1:0] col_d [LAT];
  logic [COLW-1:0] spk_d [LAT];
  logic [LAT-1:0] brt_d;

  // Colors travel beside the axis pipelines.
  always_ff @(posedge clk) begin
    if (en) begin
      col_d[0] <= star_in.star_color;
      spk_d[0] <= star_in.spike_color;
      brt_d <= {brt_d[LAT-2:0], star_in.bright_star};
      for (int i = 1; i < LAT; i++) begin
        col_d[i] <= col_d[i-1];
        spk_d[i] <= spk_d[i-1];
      end
    end
  end

  logic in_view, shows, spikes;
  logic [IW-1:0] idx_c;
  psp_pkg::psp_star_t st, st_next;

  // View test, visibility and linear address.
  assign in_view = (pos_x >= PW'(view_left)) && (pos_x < PW'(view_right)) &&
                   (pos_y >= PW'(view_top)) && (pos_y < PW'(view_bottom));
  assign shows = psp_pkg::max_channel(col_d[LAT-1]) > background_level;
  assign spikes = brt_d[LAT-1] && (psp_pkg::max_channel(spk_d[LAT-1]) > background_level);
  assign idx_c = IW'(32'(pos_y) * FIELD_WIDTH + 32'(pos_x));

  always_comb begin
    st_next.idx = idx_c;
    st_next.color = col_d[LAT-1];
    st_next.spike = spk_d[LAT-1];
    st_next.mask = '0;
    if (in_view && shows) begin
      st_next.mask[psp_pkg::WR_CENTER] = 1'b1;
      if (spikes && (32'(pos_y) < FIELD_HEIGHT - 1)) begin
        st_next.mask[psp_pkg::WR_RIGHT] = 1'b1;
        st_next.mask[psp_pkg::WR_DOWN] = 1'b1;
      end
      if (spikes && (pos_y != '0)) begin
        st_next.mask[psp_pkg::WR_LEFT] = 1'b1;
        st_next.mask[psp_pkg::WR_UP] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st <= st_next;
    end
  end

  psp_emit #(.FIELD(FIELD_WIDTH)) u_emit (
    .clk(clk), .rst(rst), .load_valid(vld[LAT]), .load(st), .can_load(can_load),
    .pixel_out(pixel_out)
  );

endmodule

@@ bench/psp_checker.sv @@
// Checker for the parallax starfield plotter: watches both channels, predicts pixel writes.
// Depends on psp_pkg, psp_star_if and psp_pixel_if; configuration mirrored from the write port.
`timescale 1ns / 100ps

module psp_checker (
  input  logic                          clk,
  input  logic                          rst,
  psp_star_if.monitor                   star_mon,
  psp_pixel_if.monitor                  pixel_mon,
  input  logic                          write_enable,
  input  logic [psp_pkg::REG_IDX_W-1:0] reg_index,
  input  logic [psp_pkg::DATA_W-1:0]    write_data,
  output int                            fail_count,
  output int                            pending_writes,
  output int                            writes_seen
);

  localparam int FW = 1024;
  localparam int FH = 1024;
  localparam int MAXD = 20;

  typedef struct packed {
    logic [psp_pkg::INDEX_W-1:0] idx;
    logic [psp_pkg::COLOR_W-1:0] color;
    logic                        last;
  } pixel_write_t;

  pixel_write_t expected_writes[$];

  // Mirrored configuration.
  logic signed [psp_pkg::CENTER_W-1:0] cx, cy;
  logic [psp_pkg::COORD_W-1:0] vl, vt, vr, vb;
  logic [psp_pkg::LEVEL_W-1:0] bg;

  // Brightest channel of a packed color.
  function automatic int brightest(input logic [psp_pkg::COLOR_W-1:0] c);
    int m;
    m = c[23:16];
    if (c[15:8] > m) m = c[15:8];
    if (c[7:0] > m) m = c[7:0];
    return m;
  endfunction

  // Parallax shift, truncated toward zero.
  function automatic longint shift_for(input longint ctr, input int d);
    if (d == 0) return 1;
    return (4 * ctr) / longint'(d * d);
  endfunction

  function automatic longint wrap_into(input longint v, input longint m);
    longint r;
    r = v % m;
    if (r < 0) r += m;
    return r;
  endfunction

  // Queue the writes caused by one star.
  task automatic plot_star(input logic [psp_pkg::COORD_W-1:0] sx,
                           input logic [psp_pkg::COORD_W-1:0] sy,
                           input logic [psp_pkg::DEPTH_W-1:0] dep,
                           input logic [psp_pkg::COLOR_W-1:0] col,
                           input logic [psp_pkg::COLOR_W-1:0] spk, input logic bright);
    int d;
    longint x, y, idx;
    d = dep > MAXD ? MAXD : dep;
    x = wrap_into(longint'(sx) - shift_for(longint'(cx), d), FW);
    y = wrap_into(longint'(sy) + shift_for(longint'(cy), d), FH);
    if (x < vl || x >= vr || y < vt || y >= vb) return;
    if (brightest(col) <= bg) return;
    idx = y * FW + x;
    if (bright && bg < brightest(spk)) begin
      if (y < FH - 1) begin
        expected_writes.push_back({psp_pkg::INDEX_W'(idx + 1), spk, 1'b0});
        expected_writes.push_back({psp_pkg::INDEX_W'(idx + FW), spk, 1'b0});
      end
      if (y > 0) begin
        expected_writes.push_back({psp_pkg::INDEX_W'(idx - 1), spk, 1'b0});
        expected_writes.push_back({psp_pkg::INDEX_W'(idx - FW), spk, 1'b0});
      end
    end
    expected_writes.push_back({psp_pkg::INDEX_W'(idx), col, 1'b1});
  endtask

  assign pending_writes = expected_writes.size();

  always @(posedge clk) begin
    pixel_write_t e;
    if (rst) begin
      cx <= '0; cy <= '0; vl <= '0; vt <= '0; vr <= 11'd1024; vb <= 11'd1024; bg <= '0;
      fail_count <= 0;
      writes_seen <= 0;
      expected_writes.delete();
    end else begin
      if (write_enable) begin
        case (reg_index)
          psp_pkg::REG_CENTER_X:    cx <= write_data[psp_pkg::CENTER_W-1:0];
          psp_pkg::REG_CENTER_Y:    cy <= write_data[psp_pkg::CENTER_W-1:0];
          psp_pkg::REG_VIEW_LEFT:   vl <= write_data[psp_pkg::COORD_W-1:0];
          psp_pkg::REG_VIEW_TOP:    vt <= write_data[psp_pkg::COORD_W-1:0];
          psp_pkg::REG_VIEW_RIGHT:  vr <= write_data[psp_pkg::COORD_W-1:0];
          psp_pkg::REG_VIEW_BOTTOM: vb <= write_data[psp_pkg::COORD_W-1:0];
          psp_pkg::REG_BG_LEVEL:    bg <= write_data[psp_pkg::LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (star_mon.valid && star_mon.ready)
        plot_star(star_mon.star_x, star_mon.star_y, star_mon.star_depth,
                  star_mon.star_color, star_mon.spike_color, star_mon.bright_star);
      // Compare each accepted word with the oldest expectation.
      if (pixel_mon.valid && pixel_mon.ready) begin
        writes_seen <= writes_seen + 1;
        if (expected_writes.size() == 0) begin
          $error("unexpected pixel write idx=%0h color=%0h", pixel_mon.pixel_index,
                 pixel_mon.pixel_color);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_writes.pop_front();
          if (pixel_mon.pixel_index !== e.idx || pixel_mon.pixel_color !== e.color ||
              pixel_mon.last_write !== e.last) begin
            if (pixel_mon.pixel_index !== e.idx)
              $error("pixel_index expected %0h actual %0h", e.idx, pixel_mon.pixel_index);
            if (pixel_mon.pixel_color !== e.color)
              $error("pixel_color expected %0h actual %0h", e.color, pixel_mon.pixel_color);
            if (pixel_mon.last_write !== e.last)
              $error("last_write expected %0b actual %0b", e.last, pixel_mon.last_write);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ bench/tb.sv @@
// Top of the plotter bench: clock, reset, configuration phases and star stimulus.
// Depends on psp_pkg, the channel interfaces, psp_checker and the plotter itself.
`timescale 1ns / 100ps

module tb;

  logic clk, rst;
  logic write_enable;
  logic [psp_pkg::REG_IDX_W-1:0] reg_index;
  logic [psp_pkg::DATA_W-1:0] write_data;
  int fail_count, pending_writes, writes_seen;
  int send_idle_pct, recv_idle_pct;
  int hold_cycles = 0;
  bit hold_taken = 1'b0;
  bit hold_req;
  int stars_sent;
  bit recv_free;

  psp_star_if star_ch();
  psp_pixel_if pixel_ch();

  parallax_starfield_plotter i_dut (
    .clk(clk), .rst(rst), .star_in(star_ch.sink), .pixel_out(pixel_ch.source),
    .write_enable(write_enable), .reg_index(reg_index), .write_data(write_data)
  );

  psp_checker i_checker (
    .clk(clk), .rst(rst), .star_mon(star_ch.monitor), .pixel_mon(pixel_ch.monitor),
    .write_enable(write_enable), .reg_index(reg_index), .write_data(write_data),
    .fail_count(fail_count), .pending_writes(pending_writes), .writes_seen(writes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(negedge clk) begin
    if (rst) pixel_ch.ready <= 1'b0;
    else if (hold_cycles > 0) begin
      pixel_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_req && !hold_taken) begin
      pixel_ch.ready <= 1'b0;
      hold_cycles <= 300;
      hold_taken <= 1'b1;
    end else pixel_ch.ready <= recv_free || ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one star word and wait for its acceptance.
  task automatic send_star(input logic [psp_pkg::COORD_W-1:0] x,
                           input logic [psp_pkg::COORD_W-1:0] y,
                           input logic [psp_pkg::DEPTH_W-1:0] d,
                           input logic [psp_pkg::COLOR_W-1:0] c,
                           input logic [psp_pkg::COLOR_W-1:0] s, input logic b);
    while ($urandom_range(99) < send_idle_pct) begin
      star_ch.valid <= 1'b0;
      @(negedge clk);
    end
    star_ch.valid <= 1'b1;
    star_ch.star_x <= x; star_ch.star_y <= y; star_ch.star_depth <= d;
    star_ch.star_color <= c; star_ch.spike_color <= s; star_ch.bright_star <= b;
    @(posedge clk);
    while (!star_ch.ready) @(posedge clk);
    stars_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input psp_pkg::reg_index_t r,
                           input logic [psp_pkg::DATA_W-1:0] v);
    write_enable <= 1'b1; reg_index <= r; write_data <= v;
    @(negedge clk);
    write_enable <= 1'b0;
    @(negedge clk);
  endtask

  // Drain all expected writes, then let the pipeline settle before reconfiguring.
  task automatic drain();
    star_ch.valid <= 1'b0;
    while (pending_writes != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_view(input int l, input int t, input int r, input int b, input int bgl);
    write_reg(psp_pkg::REG_VIEW_LEFT, psp_pkg::DATA_W'(l));
    write_reg(psp_pkg::REG_VIEW_TOP, psp_pkg::DATA_W'(t));
    write_reg(psp_pkg::REG_VIEW_RIGHT, psp_pkg::DATA_W'(r));
    write_reg(psp_pkg::REG_VIEW_BOTTOM, psp_pkg::DATA_W'(b));
    write_reg(psp_pkg::REG_BG_LEVEL, psp_pkg::DATA_W'(bgl));
  endtask

  // Mostly visible stars, with bright ones common and odd fields now and then.
  task automatic random_stars(input int n);
    logic [psp_pkg::COORD_W-1:0] x, y;
    logic [psp_pkg::DEPTH_W-1:0] d;
    for (int i = 0; i < n; i++) begin
      x = ($urandom_range(9) == 0) ? psp_pkg::COORD_W'($urandom) :
                                     psp_pkg::COORD_W'($urandom_range(1023));
      y = ($urandom_range(9) == 0) ? psp_pkg::COORD_W'($urandom) :
                                     psp_pkg::COORD_W'($urandom_range(1023));
      d = ($urandom_range(9) == 0) ? psp_pkg::DEPTH_W'($urandom) :
                                     psp_pkg::DEPTH_W'($urandom_range(20));
      send_star(x, y, d, psp_pkg::COLOR_W'($urandom), psp_pkg::COLOR_W'($urandom),
                1'($urandom_range(1)));
    end
  endtask

  initial begin
    rst = 1'b1;
    write_enable = 1'b0; reg_index = '0; write_data = '0;
    star_ch.valid = 1'b0; star_ch.star_x = '0; star_ch.star_y = '0;
    star_ch.star_depth = '0; star_ch.star_color = '0; star_ch.spike_color = '0;
    star_ch.bright_star = 1'b0;
    hold_req = 1'b0; recv_free = 1'b0; stars_sent = 0;
    send_idle_pct = 26; recv_idle_pct = 77;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset configuration, field extremes, edge rows, depth saturation.
    send_star(11'd0, 11'd0, 5'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    send_star(11'd1023, 11'd1023, 5'd0, 24'h010000, 24'h000001, 1'b1);
    send_star(11'd1022, 11'd1022, 5'd20, 24'h0000FF, 24'h00FF00, 1'b1);
    send_star(11'd2047, 11'd2047, 5'd31, 24'h00FF00, 24'hFFFFFF, 1'b1);
    send_star(11'd1024, 11'd1024, 5'd21, 24'h000000, 24'hFFFFFF, 1'b1);
    send_star(11'd512, 11'd0, 5'd1, 24'hFF0000, 24'h000000, 1'b1);
    send_star(11'd0, 11'd511, 5'd2, 24'h123456, 24'hABCDEF, 1'b0);
    drain();

    // Extreme viewer positions, tight view and a high background.
    write_reg(psp_pkg::REG_CENTER_X, 30'h1FFFFFFF);
    write_reg(psp_pkg::REG_CENTER_Y, 30'h20000000);
    set_view(100, 200, 900, 800, 128);
    send_star(11'd0, 11'd0, 5'd0, 24'h808080, 24'h818181, 1'b1);
    send_star(11'd500, 11'd500, 5'd1, 24'h818181, 24'h808080, 1'b1);
    send_star(11'd700, 11'd300, 5'd20, 24'hFF0000, 24'h0000FF, 1'b1);
    send_star(11'd99, 11'd199, 5'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    send_star(11'd900, 11'd800, 5'd3, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    drain();
    // Degenerate view drops everything; max background drops everything.
    set_view(600, 600, 600, 300, 255);
    send_star(11'd600, 11'd600, 5'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    send_star(11'd10, 11'd10, 5'd7, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
    drain();

    // Random phase one: sender idles 26 percent, receiver 77 percent.
    write_reg(psp_pkg::REG_CENTER_X, 30'h3FFFFFFF);
    write_reg(psp_pkg::REG_CENTER_Y, 30'd12345);
    set_view(0, 0, 1024, 1024, 40);
    random_stars(100);
    drain();

    // Phase two: roles swapped, extreme viewer (negative x, positive y), view at the max edges.
    send_idle_pct = 77; recv_idle_pct = 26;
    write_reg(psp_pkg::REG_CENTER_X, 30'h20000000);
    write_reg(psp_pkg::REG_CENTER_Y, 30'h1FFFFFFF);
    set_view(1024, 0, 1024, 1024, 0);
    random_stars(10);
    drain();
    write_reg(psp_pkg::REG_CENTER_X, psp_pkg::DATA_W'($urandom));
    write_reg(psp_pkg::REG_CENTER_Y, psp_pkg::DATA_W'($urandom));
    set_view(0, 0, 1024, 1024, 0);
    random_stars(90);
    drain();

    // Phase three: no idling, with one long receiver hold-off to back up the input.
    send_idle_pct = 0; recv_idle_pct = 0; recv_free = 1'b1;
    write_reg(psp_pkg::REG_CENTER_X, 30'd1000);
    write_reg(psp_pkg::REG_CENTER_Y, -30'sd1000);
    set_view(50, 50, 1000, 1000, 16);
    hold_req = 1'b1;
    random_stars(100);
    drain();

    $display("tb: %0d stars sent, %0d pixel writes checked", stars_sent, writes_seen);
    $display("tb: directed edge cases, stalled and back-to-back random phases, one hold-off");
    if (fail_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: FAIL");
    $finish;
  end
endmodule
